/* sv/cdpq_pkg.sv */
package cdpq_pkg;

	// Default sizes of the queue storage.
	localparam int DEPTH_DEF     = 16;
	localparam int TIME_BITS_DEF = 20;

	// Fixed field widths of the ports.
	localparam int ID_W     = 16;
	localparam int MIN_W    = 20;
	localparam int CAP_W    = 5;
	localparam int OCC_W    = 5;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;

	// A single tick reports at most this many expired items.
	localparam int MAX_EXPIRE = 16;
	localparam int EXP_W      = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 2'd0,
		FN_TICK   = 2'd1,
		FN_POP    = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_DEC_RD,
		ST_DEC_WR,
		ST_EXP_RD,
		ST_EXP_CHK,
		ST_POP
	} state_t;

	// Source of the memory read address.
	typedef enum logic [1:0] {
		RD_HEAD,
		RD_PREV,
		RD_IDX
	} addr_src_t;

	// Source of the memory write.
	typedef enum logic [1:0] {
		WR_NEW,
		WR_MOVE,
		WR_DEC
	} wr_src_t;

	// Kind of result placed on the output register.
	typedef enum logic [2:0] {
		RES_NONE,
		RES_FULL,
		RES_EMPTY,
		RES_POP,
		RES_HELD
	} res_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      ld_new;
		logic      rd_en;
		addr_src_t rd_src;
		logic      wr_en;
		wr_src_t   wr_src;
		logic      idx_clr;
		logic      idx_inc;
		logic      take_head;
		logic      exp_clr;
		logic      exp_hold;
		logic      emit;
		res_kind_t res_kind;
		logic      last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic at_head;
		logic sweep_done;
		logic new_less;
		logic rd_zero;
		logic exp_none;
		logic exp_max;
	} sts_t;

endpackage

/* sv/cdpq_ctrl.sv */
module cdpq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cdpq_pkg::func_t  func,
	input  cdpq_pkg::sts_t   sts,
	output logic             busy,
	output cdpq_pkg::cmd_t   cmd
);

	cdpq_pkg::state_t state_q;
	cdpq_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdpq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cdpq_pkg::ST_IDLE: begin
				if (start) begin
					unique case (func)
						cdpq_pkg::FN_INSERT: begin
							if (!sts.full) state_d = cdpq_pkg::ST_INS_RD;
						end
						cdpq_pkg::FN_TICK: state_d = cdpq_pkg::ST_DEC_RD;
						cdpq_pkg::FN_POP: begin
							if (!sts.empty) state_d = cdpq_pkg::ST_POP;
						end
						default: state_d = cdpq_pkg::ST_IDLE;
					endcase
				end
			end
			cdpq_pkg::ST_INS_RD: begin
				state_d = sts.at_head ? cdpq_pkg::ST_IDLE : cdpq_pkg::ST_INS_CMP;
			end
			cdpq_pkg::ST_INS_CMP: begin
				state_d = sts.new_less ? cdpq_pkg::ST_INS_RD : cdpq_pkg::ST_IDLE;
			end
			cdpq_pkg::ST_DEC_RD: begin
				state_d = sts.sweep_done ? cdpq_pkg::ST_EXP_RD : cdpq_pkg::ST_DEC_WR;
			end
			cdpq_pkg::ST_DEC_WR: state_d = cdpq_pkg::ST_DEC_RD;
			cdpq_pkg::ST_EXP_RD: begin
				state_d = (sts.empty || sts.exp_max) ? cdpq_pkg::ST_IDLE : cdpq_pkg::ST_EXP_CHK;
			end
			cdpq_pkg::ST_EXP_CHK: begin
				state_d = sts.rd_zero ? cdpq_pkg::ST_EXP_RD : cdpq_pkg::ST_IDLE;
			end
			cdpq_pkg::ST_POP: state_d = cdpq_pkg::ST_IDLE;
			default: state_d = cdpq_pkg::ST_IDLE;
		endcase
	end

	// Commands for the datapath.
	always_comb begin
		cmd          = '0;
		cmd.rd_src   = cdpq_pkg::RD_HEAD;
		cmd.wr_src   = cdpq_pkg::WR_NEW;
		cmd.res_kind = cdpq_pkg::RES_NONE;
		busy         = (state_q != cdpq_pkg::ST_IDLE);
		unique case (state_q)
			cdpq_pkg::ST_IDLE: begin
				if (start) begin
					unique case (func)
						cdpq_pkg::FN_INSERT: begin
							if (sts.full) begin
								cmd.emit     = 1'b1;
								cmd.res_kind = cdpq_pkg::RES_FULL;
								cmd.last     = 1'b1;
							end else begin
								cmd.ld_new = 1'b1;
							end
						end
						cdpq_pkg::FN_TICK: begin
							cmd.idx_clr = 1'b1;
							cmd.exp_clr = 1'b1;
						end
						cdpq_pkg::FN_POP: begin
							if (sts.empty) begin
								cmd.emit     = 1'b1;
								cmd.res_kind = cdpq_pkg::RES_EMPTY;
								cmd.last     = 1'b1;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_src = cdpq_pkg::RD_HEAD;
							end
						end
						default: begin
							cmd.emit     = 1'b1;
							cmd.res_kind = cdpq_pkg::RES_NONE;
							cmd.last     = 1'b1;
						end
					endcase
				end
			end
			cdpq_pkg::ST_INS_RD: begin
				if (sts.at_head) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_src   = cdpq_pkg::WR_NEW;
					cmd.emit     = 1'b1;
					cmd.res_kind = cdpq_pkg::RES_NONE;
					cmd.last     = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = cdpq_pkg::RD_PREV;
				end
			end
			cdpq_pkg::ST_INS_CMP: begin
				cmd.wr_en = 1'b1;
				if (sts.new_less) begin
					cmd.wr_src = cdpq_pkg::WR_MOVE;
				end else begin
					cmd.wr_src   = cdpq_pkg::WR_NEW;
					cmd.emit     = 1'b1;
					cmd.res_kind = cdpq_pkg::RES_NONE;
					cmd.last     = 1'b1;
				end
			end
			cdpq_pkg::ST_DEC_RD: begin
				if (!sts.sweep_done) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_src  = cdpq_pkg::RD_IDX;
					cmd.idx_inc = 1'b1;
				end
			end
			cdpq_pkg::ST_DEC_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = cdpq_pkg::WR_DEC;
			end
			cdpq_pkg::ST_EXP_RD: begin
				if (sts.empty || sts.exp_max) begin
					cmd.emit     = 1'b1;
					cmd.res_kind = sts.exp_none ? cdpq_pkg::RES_NONE : cdpq_pkg::RES_HELD;
					cmd.last     = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = cdpq_pkg::RD_HEAD;
				end
			end
			cdpq_pkg::ST_EXP_CHK: begin
				if (sts.rd_zero) begin
					// Release the item held from the previous expiry; this one waits.
					cmd.emit      = !sts.exp_none;
					cmd.res_kind  = cdpq_pkg::RES_HELD;
					cmd.exp_hold  = 1'b1;
					cmd.take_head = 1'b1;
				end else begin
					cmd.emit     = 1'b1;
					cmd.res_kind = sts.exp_none ? cdpq_pkg::RES_NONE : cdpq_pkg::RES_HELD;
					cmd.last     = 1'b1;
				end
			end
			cdpq_pkg::ST_POP: begin
				cmd.emit      = 1'b1;
				cmd.res_kind  = cdpq_pkg::RES_POP;
				cmd.last      = 1'b1;
				cmd.take_head = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* sv/cdpq_dp.sv */
module cdpq_dp #(
	parameter int DEPTH     = cdpq_pkg::DEPTH_DEF,
	parameter int TIME_BITS = cdpq_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cdpq_pkg::CAP_W-1:0]     cfg_wdata,
	input  logic [cdpq_pkg::ID_W-1:0]      item_id,
	input  logic [cdpq_pkg::MIN_W-1:0]     delay_minutes,
	input  cdpq_pkg::cmd_t                 cmd,
	output cdpq_pkg::sts_t                 sts,
	output logic                           result_strobe,
	output logic                           item_valid,
	output logic [cdpq_pkg::ID_W-1:0]      out_id,
	output logic [cdpq_pkg::MIN_W-1:0]     out_minutes,
	output logic                           last,
	output logic [cdpq_pkg::STATUS_W-1:0]  status,
	output logic [cdpq_pkg::OCC_W-1:0]     occupancy,
	output logic                           is_full
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SW    = CNT_W + 1;
	localparam int ID_W  = cdpq_pkg::ID_W;
	localparam int MIN_W = cdpq_pkg::MIN_W;
	localparam int EXP_W = cdpq_pkg::EXP_W;

	// Entry storage.
	logic [ID_W-1:0]      mem_id_q  [DEPTH];
	logic [TIME_BITS-1:0] mem_min_q [DEPTH];

	logic [AW-1:0]        head_q;
	logic [CNT_W-1:0]     count_q;
	logic [cdpq_pkg::CAP_W-1:0] cap_q;
	logic [AW-1:0]        pos_q;
	logic [CNT_W-1:0]     idx_q;
	logic [EXP_W-1:0]     nexp_q;
	logic [ID_W-1:0]      new_id_q;
	logic [TIME_BITS-1:0] new_min_q;
	logic [ID_W-1:0]      hold_id_q;
	logic [ID_W-1:0]      rd_id_q;
	logic [TIME_BITS-1:0] rd_min_q;
	logic [AW-1:0]        rd_addr_q;

	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        wr_addr;
	logic [ID_W-1:0]      wr_id;
	logic [TIME_BITS-1:0] wr_min;
	logic [AW-1:0]        prev_pos;
	logic [AW-1:0]        tail_slot;
	logic [AW-1:0]        idx_slot;
	logic [AW-1:0]        head_inc;
	logic [CNT_W-1:0]     eff_cap;
	logic [CNT_W-1:0]     res_occ;
	logic [31:0]          cap_wide;
	logic [31:0]          occ_wide;
	logic [TIME_BITS+MIN_W-1:0] din_wide;
	logic [TIME_BITS+MIN_W-1:0] dout_wide;

	// Position in the ring at a given distance from the head.
	function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
		input logic [CNT_W-1:0] offset);
		logic [SW-1:0] sum;
		logic [SW-1:0] wrapped;
		sum     = SW'(base) + SW'(offset);
		wrapped = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
		return wrapped[AW-1:0];
	endfunction

	// Ring addresses.
	assign tail_slot = ring_slot(head_q, count_q);
	assign idx_slot  = ring_slot(head_q, idx_q);
	assign prev_pos  = (pos_q == '0) ? AW'(DEPTH - 1) : (pos_q - 1'b1);
	assign head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : (head_q + 1'b1);

	// Effective capacity: zero acts as one, anything above the depth as the depth.
	assign cap_wide = {{(32 - cdpq_pkg::CAP_W){1'b0}}, cap_q};
	always_comb begin
		priority if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (cap_wide > 32'(DEPTH)) begin
			eff_cap = CNT_W'(DEPTH);
		end else begin
			eff_cap = cap_wide[CNT_W-1:0];
		end
	end

	// Status toward the controller.
	assign sts.empty      = (count_q == '0);
	assign sts.full       = (count_q >= eff_cap);
	assign sts.at_head    = (pos_q == head_q);
	assign sts.sweep_done = (idx_q == count_q);
	assign sts.new_less   = (new_min_q < rd_min_q);
	assign sts.rd_zero    = (rd_min_q == '0);
	assign sts.exp_none   = (nexp_q == '0);
	assign sts.exp_max    = (nexp_q == EXP_W'(cdpq_pkg::MAX_EXPIRE));

	// Memory address and write data selection.
	always_comb begin
		unique case (cmd.rd_src)
			cdpq_pkg::RD_HEAD: rd_addr = head_q;
			cdpq_pkg::RD_PREV: rd_addr = prev_pos;
			cdpq_pkg::RD_IDX:  rd_addr = idx_slot;
			default:           rd_addr = head_q;
		endcase
		unique case (cmd.wr_src)
			cdpq_pkg::WR_NEW: begin
				wr_addr = pos_q;
				wr_id   = new_id_q;
				wr_min  = new_min_q;
			end
			cdpq_pkg::WR_MOVE: begin
				wr_addr = pos_q;
				wr_id   = rd_id_q;
				wr_min  = rd_min_q;
			end
			cdpq_pkg::WR_DEC: begin
				wr_addr = rd_addr_q;
				wr_id   = rd_id_q;
				wr_min  = (rd_min_q != '0) ? (rd_min_q - 1'b1) : '0;
			end
			default: begin
				wr_addr = pos_q;
				wr_id   = new_id_q;
				wr_min  = new_min_q;
			end
		endcase
	end

	// Entry memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_id_q[wr_addr]  <= wr_id;
			mem_min_q[wr_addr] <= wr_min;
		end
		if (cmd.rd_en) begin
			rd_id_q   <= mem_id_q[rd_addr];
			rd_min_q  <= mem_min_q[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// The incoming time is fitted to the stored time width.
	assign din_wide = {{TIME_BITS{1'b0}}, delay_minutes};

	// Item being inserted and the item held back by the expiry loop.
	always_ff @(posedge clk) begin
		if (cmd.ld_new) begin
			new_id_q  <= item_id;
			new_min_q <= din_wide[TIME_BITS-1:0];
		end
		if (cmd.exp_hold) begin
			hold_id_q <= rd_id_q;
		end
	end

	// Queue pointers, counters and the capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			cap_q   <= cdpq_pkg::CAP_RESET;
			pos_q   <= '0;
			idx_q   <= '0;
			nexp_q  <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.ld_new) begin
				pos_q   <= tail_slot;
				count_q <= count_q + 1'b1;
			end else if (cmd.take_head) begin
				count_q <= count_q - 1'b1;
				head_q  <= (count_q == CNT_W'(1)) ? '0 : head_inc;
			end
			if (cmd.wr_en && (cmd.wr_src == cdpq_pkg::WR_MOVE)) begin
				pos_q <= prev_pos;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.exp_clr) begin
				nexp_q <= '0;
			end else if (cmd.exp_hold) begin
				nexp_q <= nexp_q + 1'b1;
			end
		end
	end

	// A pop shows the count after its own removal.
	assign res_occ   = (cmd.res_kind == cdpq_pkg::RES_POP) ? (count_q - 1'b1) : count_q;
	assign occ_wide  = {{(32 - CNT_W){1'b0}}, res_occ};
	assign dout_wide = {{MIN_W{1'b0}}, rd_min_q};

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.emit;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last      <= cmd.last;
			occupancy <= occ_wide[cdpq_pkg::OCC_W-1:0];
			is_full   <= (res_occ >= eff_cap);
			unique case (cmd.res_kind)
				cdpq_pkg::RES_POP: begin
					item_valid  <= 1'b1;
					out_id      <= rd_id_q;
					out_minutes <= dout_wide[MIN_W-1:0];
					status      <= cdpq_pkg::STS_OK;
				end
				cdpq_pkg::RES_HELD: begin
					item_valid  <= 1'b1;
					out_id      <= hold_id_q;
					out_minutes <= '0;
					status      <= cdpq_pkg::STS_OK;
				end
				cdpq_pkg::RES_FULL: begin
					item_valid  <= 1'b0;
					out_id      <= '0;
					out_minutes <= '0;
					status      <= cdpq_pkg::STS_FULL;
				end
				cdpq_pkg::RES_EMPTY: begin
					item_valid  <= 1'b0;
					out_id      <= '0;
					out_minutes <= '0;
					status      <= cdpq_pkg::STS_EMPTY;
				end
				default: begin
					item_valid  <= 1'b0;
					out_id      <= '0;
					out_minutes <= '0;
					status      <= cdpq_pkg::STS_OK;
				end
			endcase
		end
	end

endmodule

/* sv/countdown_priority_queue.sv */
// Channel     Ports                                        Handshake
// command     start, func, item_id, delay_minutes, busy    start high while busy low
// result      result_strobe, item_valid, out_id,           one-cycle strobe, no stall
//             out_minutes, last, status, occupancy, is_full
// config      cfg_we, cfg_wdata                            write when cfg_we high
//
// Entries live in a ring memory with one write port and one registered read
// port. An insert moves each larger entry up one slot, tail first, until it
// meets the head or an entry that is not larger; a tick counts every stored
// time down, then takes expired items from the head until the queue is empty,
// the limit is reached or an unexpired item ends the scan; a pop reads the
// head. Results leave in the cycle after the deciding one; the receiver cannot
// stall. Reset clears the pointers and count at once and sets the capacity to 16.
module countdown_priority_queue #(
	parameter int DEPTH     = cdpq_pkg::DEPTH_DEF,
	parameter int TIME_BITS = cdpq_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cdpq_pkg::FUNC_W-1:0]    func,
	input  logic [cdpq_pkg::ID_W-1:0]      item_id,
	input  logic [cdpq_pkg::MIN_W-1:0]     delay_minutes,
	output logic                           busy,
	input  logic                           cfg_we,
	input  logic [cdpq_pkg::CAP_W-1:0]     cfg_wdata,
	output logic                           result_strobe,
	output logic                           item_valid,
	output logic [cdpq_pkg::ID_W-1:0]      out_id,
	output logic [cdpq_pkg::MIN_W-1:0]     out_minutes,
	output logic                           last,
	output logic [cdpq_pkg::STATUS_W-1:0]  status,
	output logic [cdpq_pkg::OCC_W-1:0]     occupancy,
	output logic                           is_full
);

	cdpq_pkg::cmd_t cmd;
	cdpq_pkg::sts_t sts;

	// Sequencer for insert, tick and pop.
	cdpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (cdpq_pkg::func_t'(func)),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Ring memory, pointers and result register.
	cdpq_dp #(
		.DEPTH     (DEPTH),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.item_id       (item_id),
		.delay_minutes (delay_minutes),
		.cmd           (cmd),
		.sts           (sts),
		.result_strobe (result_strobe),
		.item_valid    (item_valid),
		.out_id        (out_id),
		.out_minutes   (out_minutes),
		.last          (last),
		.status        (status),
		.occupancy     (occupancy),
		.is_full       (is_full)
	);

`ifndef SYNTHESIS
	// Every multi-cycle transaction ends with its final result.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_strobe && last))
		else $error("busy dropped without a final result");

	// The head is never taken from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_head |-> !sts.empty)
		else $error("head taken from an empty queue");

	// A result that carries an item always reports success.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && item_valid) |-> (status == cdpq_pkg::STS_OK))
		else $error("item result with error status");

	// An insert is only started when there is room for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_new |=> !$past(sts.full))
		else $error("insert started on a full queue");
`endif

endmodule
